>>> rtl/core/ios_pkg.sv
// Shared constants and codes for the I/O size statistics block.
`default_nettype none
package ios_pkg;
   localparam int DEVICE_SLOTS_DEF = 16;
   localparam int BUCKETS_DEF      = 12;
   localparam int UNIT_W           = 21;
   localparam int BYTES_W          = 32;
   localparam int SECTOR_W         = 54;
   localparam int SEL_W            = 5;
   localparam int DEV_W            = 4;
   localparam int BUCKET_W         = 4;
   localparam int WORD_W           = 64;
   localparam int SECTOR_SHIFT     = 9;

   localparam logic       MODE_RECORD = 1'b0;
   localparam logic       MODE_READ   = 1'b1;
   localparam logic [1:0] OP_READ     = 2'd0;
   localparam logic [1:0] OP_WRITE    = 2'd1;

   localparam logic [2:0] FLD_BYTES = 3'd0;
   localparam logic [2:0] FLD_COUNT = 3'd1;
   localparam logic [2:0] FLD_HIST  = 3'd2;
   localparam logic [2:0] FLD_SPAN  = 3'd3;
   localparam logic [2:0] FLD_SMALL = 3'd4;
   localparam logic [2:0] FLD_MIN   = 3'd5;
   localparam logic [2:0] FLD_MAX   = 3'd6;
endpackage
`default_nettype wire

>>> rtl/core/block_io_size_statistics.sv
// Top level of the per-slot, per-direction I/O size statistics block.
//
// An item on the req_ channel either records a storage request (mode 0) or
// reads one counter (mode 1). Each record request of a read or write updates
// the record of its slot and direction: bytes, count, size histogram, span,
// small-request count, smallest and largest size. One rsp_ item comes back
// for every item. The user writes the unit size over the csr_ port only while
// the block is idle; the block itself does not enforce this. All counters live
// in one RAM and are updated read-modify-write, a read state then a modify
// state per word, seven words per record request. A record request passes
// through the divide state (two bits per cycle) and the span state only when
// span accounting is active; a counter read does a single read step, and a
// skipped request or a read that selects nothing goes straight to the finish
// state. Items are processed one at a time. After reset the block clears all
// DEVICE_SLOTS*2*(BUCKETS+6) RAM words, holding req_stall high. The result
// sits in an output register; while rsp_stall holds it, the next item is still
// taken and worked on, and its result waits for the output register to free.
`default_nettype none
module block_io_size_statistics
   import ios_pkg::*;
#(
   parameter int DEVICE_SLOTS = DEVICE_SLOTS_DEF,
   parameter int BUCKETS      = BUCKETS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [UNIT_W-1:0]   csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_mode,
   input  wire logic [1:0]          req_op_code,
   input  wire logic [DEV_W-1:0]    req_device,
   input  wire logic [BYTES_W-1:0]  req_request_bytes,
   input  wire logic [SECTOR_W-1:0] req_start_sector,
   input  wire logic [SEL_W-1:0]    req_counter_select,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_skipped,
   output logic [BUCKET_W-1:0]      rsp_bucket,
   output logic [WORD_W-1:0]        rsp_span_bytes,
   output logic                     rsp_below_unit,
   output logic [WORD_W-1:0]        rsp_counter_value
);
   localparam int RECORDS = DEVICE_SLOTS * 2;
   localparam int WORDS   = BUCKETS + 6;
   localparam int DEPTH   = RECORDS * WORDS;
   localparam int AW      = $clog2(DEPTH);
   localparam int BKT_W   = $clog2(BUCKETS);
   localparam int UNITS_W = BYTES_W - SECTOR_SHIFT;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_SPAN  = 7'b0001000,
      ST_RD    = 7'b0010000,
      ST_MOD   = 7'b0100000,
      ST_FIN   = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_cnt_ff;
   logic [UNIT_W-1:0]    unit_ff;
   logic                 mode_ff;
   logic [BYTES_W-1:0]   bytes_ff;
   logic [WORD_W-1:0]    start_ff;
   logic [WORD_W-1:0]    last_ff;
   logic [AW-1:0]        base_ff;
   logic [SEL_W-1:0]     sel_ff;
   logic [BKT_W-1:0]     bucket_ff;
   logic [2:0]           fidx_ff;
   logic                 go_ff;
   logic [WORD_W-1:0]    span_ff;
   logic                 below_ff;
   logic                 skipped_ff;
   logic [WORD_W-1:0]    value_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_skipped_ff;
   logic [BUCKET_W-1:0]  rsp_bucket_ff;
   logic [WORD_W-1:0]    rsp_span_ff;
   logic                 rsp_below_ff;
   logic [WORD_W-1:0]    rsp_value_ff;

   logic                 accept;
   logic                 rec_ok;
   logic [WORD_W-1:0]    start_c;
   logic [UNITS_W-1:0]   units_c;
   logic [BKT_W-1:0]     bucket_c;
   logic [AW-1:0]        offset;
   logic [AW-1:0]        field_addr;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_W-1:0]    mem_wdata;
   logic [WORD_W-1:0]    mem_rdata;
   logic [WORD_W-1:0]    new_word;
   logic [BYTES_W-1:0]   old_lo;
   logic                 div_done;
   logic                 div_done_l;
   logic [UNIT_W-1:0]    rem_first;
   logic [UNIT_W-1:0]    rem_last;
   logic                 out_free;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign rec_ok   = (req_op_code == OP_READ || req_op_code == OP_WRITE) &&
                     (32'(req_device) < DEVICE_SLOTS);
   assign start_c  = {1'b0, req_start_sector, {SECTOR_SHIFT{1'b0}}};
   assign units_c  = req_request_bytes[BYTES_W-1:SECTOR_SHIFT];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      bucket_c = '0;
      for (int i = 1; i < BUCKETS; i++) begin
         if ((units_c >> i) != '0) begin
            bucket_c = BKT_W'(i);
         end
      end
   end

   always_comb begin
      case (fidx_ff)
         FLD_BYTES: offset = AW'(0);
         FLD_COUNT: offset = AW'(1);
         FLD_HIST:  offset = AW'(2) + AW'(bucket_ff);
         FLD_SPAN:  offset = AW'(BUCKETS + 2);
         FLD_SMALL: offset = AW'(BUCKETS + 3);
         FLD_MIN:   offset = AW'(BUCKETS + 4);
         FLD_MAX:   offset = AW'(BUCKETS + 5);
         default:   offset = AW'(0);
      endcase
   end

   assign field_addr = base_ff + ((mode_ff == MODE_READ) ? AW'(sel_ff) : offset);
   assign old_lo     = mem_rdata[BYTES_W-1:0];

   always_comb begin
      case (fidx_ff)
         FLD_BYTES: new_word = mem_rdata + WORD_W'(bytes_ff);
         FLD_COUNT: new_word = mem_rdata + WORD_W'(1);
         FLD_HIST:  new_word = mem_rdata + WORD_W'(1);
         FLD_SPAN:  new_word = mem_rdata + span_ff;
         FLD_SMALL: new_word = mem_rdata + WORD_W'(below_ff);
         FLD_MIN:   new_word = (old_lo == '0 || bytes_ff < old_lo) ?
                               WORD_W'(bytes_ff) : WORD_W'(old_lo);
         FLD_MAX:   new_word = (bytes_ff > old_lo) ? WORD_W'(bytes_ff) : WORD_W'(old_lo);
         default:   new_word = mem_rdata;
      endcase
   end

   assign mem_we    = (state_ff == ST_CLEAR) ||
                      (state_ff == ST_MOD && mode_ff == MODE_RECORD);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : field_addr;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : new_word;

   ios_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
      .clock        (clock),
      .write_enable (mem_we),
      .write_addr   (mem_waddr),
      .write_data   (mem_wdata),
      .read_addr    (field_addr),
      .read_data    (mem_rdata)
   );

   ios_div u_div_first (
      .clock     (clock),
      .reset     (reset),
      .start     (go_ff),
      .dividend  (start_ff),
      .divisor   (unit_ff),
      .done      (div_done),
      .remainder (rem_first)
   );

   ios_div u_div_last (
      .clock     (clock),
      .reset     (reset),
      .start     (go_ff),
      .dividend  (last_ff),
      .divisor   (unit_ff),
      .done      (div_done_l),
      .remainder (rem_last)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_READ) begin
                  state_in = (rec_ok && 32'(req_counter_select) < WORDS) ? ST_RD : ST_FIN;
               end else if (!rec_ok) begin
                  state_in = ST_FIN;
               end else if (unit_ff != '0 && req_request_bytes != '0) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: state_in = ST_RD;
         ST_RD:   state_in = ST_MOD;
         ST_MOD: begin
            if (mode_ff == MODE_READ || fidx_ff == FLD_MAX) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         unit_ff      <= '0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= 1'b0;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (csr_write_enable) begin
            unit_ff <= csr_write_data;
         end
         if (accept && state_in == ST_DIV) begin
            go_ff <= 1'b1;
         end
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_mode;
         bytes_ff   <= req_request_bytes;
         sel_ff     <= req_counter_select;
         start_ff   <= start_c;
         last_ff    <= start_c + WORD_W'(req_request_bytes) - WORD_W'(1);
         base_ff    <= AW'(32'({req_device, req_op_code[0]}) * WORDS);
         fidx_ff    <= FLD_BYTES;
         span_ff    <= '0;
         value_ff   <= '0;
         skipped_ff <= (req_mode == MODE_RECORD) && !rec_ok;
         bucket_ff  <= (req_mode == MODE_RECORD && rec_ok) ? bucket_c : '0;
         below_ff   <= (req_mode == MODE_RECORD) && rec_ok && (unit_ff != '0) &&
                       (req_request_bytes < BYTES_W'(unit_ff));
      end
      if (state_ff == ST_SPAN) begin
         span_ff <= (last_ff - WORD_W'(rem_last)) - (start_ff - WORD_W'(rem_first)) +
                    WORD_W'(unit_ff);
      end
      if (state_ff == ST_MOD) begin
         if (mode_ff == MODE_READ) begin
            value_ff <= mem_rdata;
         end else begin
            fidx_ff <= fidx_ff + 3'd1;
         end
      end
      if (state_ff == ST_FIN && out_free) begin
         rsp_skipped_ff <= skipped_ff;
         rsp_bucket_ff  <= BUCKET_W'(bucket_ff);
         rsp_span_ff    <= span_ff;
         rsp_below_ff   <= below_ff;
         rsp_value_ff   <= value_ff;
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_skipped       = rsp_skipped_ff;
   assign rsp_bucket        = rsp_bucket_ff;
   assign rsp_span_bytes    = rsp_span_ff;
   assign rsp_below_unit    = rsp_below_ff;
   assign rsp_counter_value = rsp_value_ff;

   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("item taken during clearing pass");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("remainder finished outside the divide state");

   a_div_paired: assert property (@(posedge clock) disable iff (reset)
      div_done == div_done_l)
      else $error("remainder units out of step");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not presented");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || $past(state_ff) == ST_RD))
      else $error("RAM write without a preceding read");
endmodule
`default_nettype wire

>>> rtl/core/ios_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ios_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 576
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data <= mem_ff[read_addr];
   end
endmodule
`default_nettype wire

>>> rtl/core/ios_div.sv
// Iterative remainder unit, two quotient bits per cycle, for the span computation.
`default_nettype none
module ios_div
   import ios_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WORD_W-1:0] dividend,
   input  wire logic [UNIT_W-1:0] divisor,
   output logic                   done,
   output logic      [UNIT_W-1:0] remainder
);
   localparam int STEPS = WORD_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic [WORD_W-1:0] shift_ff;
   logic [UNIT_W-1:0] rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   function automatic logic [UNIT_W-1:0] rem_step(input logic [UNIT_W-1:0] r,
                                                  input logic b,
                                                  input logic [UNIT_W-1:0] d);
      logic [UNIT_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[UNIT_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            cnt_ff   <= '0;
            rem_ff   <= '0;
            shift_ff <= dividend;
         end else if (busy_ff) begin
            rem_ff   <= rem_step(rem_step(rem_ff, shift_ff[WORD_W-1], divisor),
                                 shift_ff[WORD_W-2], divisor);
            shift_ff <= {shift_ff[WORD_W-3:0], 2'b00};
            cnt_ff   <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

>>> verif/block_io_size_statistics_tb.sv
// Self-checking testbench for the I/O size statistics block with a built-in predictor.
`default_nettype none
module block_io_size_statistics_tb;
   import ios_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = DEVICE_SLOTS_DEF;
   localparam int NBKT  = BUCKETS_DEF;
   localparam int RECS  = SLOTS * 2;
   localparam logic [SEL_W-1:0] SEL_BYTES = 5'd0;
   localparam logic [SEL_W-1:0] SEL_COUNT = 5'd1;
   localparam logic [SEL_W-1:0] SEL_HIST0 = 5'd2;
   localparam logic [SEL_W-1:0] SEL_SPAN  = SEL_HIST0 + NBKT;
   localparam logic [SEL_W-1:0] SEL_SMALL = SEL_SPAN + 1;
   localparam logic [SEL_W-1:0] SEL_MIN   = SEL_SPAN + 2;
   localparam logic [SEL_W-1:0] SEL_MAX   = SEL_SPAN + 3;
   localparam logic [1:0] OP_OTHER  = 2'd2;
   localparam logic [1:0] OP_OTHER3 = 2'd3;

   typedef struct packed {
      logic                mode;
      logic [1:0]          op;
      logic [DEV_W-1:0]    dev;
      logic [BYTES_W-1:0]  bytes;
      logic [SECTOR_W-1:0] sector;
      logic [SEL_W-1:0]    sel;
   } io_item_type;

   typedef struct packed {
      logic                skipped;
      logic [BUCKET_W-1:0] bucket;
      logic [WORD_W-1:0]   span;
      logic                below;
      logic [WORD_W-1:0]   value;
   } io_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [UNIT_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   io_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_skipped, rsp_below_unit;
   logic [BUCKET_W-1:0] rsp_bucket;
   logic [WORD_W-1:0] rsp_span_bytes, rsp_counter_value;

   block_io_size_statistics DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_item.mode), .req_op_code(req_item.op), .req_device(req_item.dev),
      .req_request_bytes(req_item.bytes), .req_start_sector(req_item.sector),
      .req_counter_select(req_item.sel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_skipped(rsp_skipped),
      .rsp_bucket(rsp_bucket), .rsp_span_bytes(rsp_span_bytes),
      .rsp_below_unit(rsp_below_unit), .rsp_counter_value(rsp_counter_value)
   );

   always #1 clock = ~clock;

   // Predictor state.
   logic [WORD_W-1:0] byte_sum [RECS];
   logic [WORD_W-1:0] req_sum [RECS];
   logic [WORD_W-1:0] hist_sum [RECS][NBKT];
   logic [WORD_W-1:0] span_sum [RECS];
   logic [WORD_W-1:0] small_sum [RECS];
   logic [BYTES_W-1:0] min_size [RECS];
   logic [BYTES_W-1:0] max_size [RECS];
   logic [UNIT_W-1:0] unit_bytes = '0;

   io_item_type pending_items[$];
   io_result_type expected_results[$];
   int mismatches = 0;
   int idle_pct = 15;
   bit hold_rsp = 0;
   bit req_taken = 0;

   function automatic logic [BUCKET_W-1:0] size_bin(logic [BYTES_W-1:0] bytes);
      logic [BYTES_W-1:0] units;
      int b;
      units = bytes >> SECTOR_SHIFT;
      b = 0;
      while (b < NBKT - 1 && units > 1) begin
         units = units >> 1;
         b++;
      end
      return b[BUCKET_W-1:0];
   endfunction

   function automatic io_result_type predict_and_update(io_item_type it);
      io_result_type r;
      int rec;
      logic [WORD_W-1:0] first_byte, last_byte, span;
      r = '0;
      rec = it.dev * 2 + it.op;
      if (it.mode == MODE_READ) begin
         if (it.op <= OP_WRITE) begin
            if (it.sel == SEL_BYTES) r.value = byte_sum[rec];
            else if (it.sel == SEL_COUNT) r.value = req_sum[rec];
            else if (it.sel < SEL_SPAN) r.value = hist_sum[rec][it.sel - SEL_HIST0];
            else if (it.sel == SEL_SPAN) r.value = span_sum[rec];
            else if (it.sel == SEL_SMALL) r.value = small_sum[rec];
            else if (it.sel == SEL_MIN) r.value = min_size[rec];
            else if (it.sel == SEL_MAX) r.value = max_size[rec];
         end
         return r;
      end
      if (it.op > OP_WRITE) begin
         r.skipped = 1'b1;
         return r;
      end
      byte_sum[rec] += it.bytes;
      req_sum[rec] += 1;
      if (min_size[rec] == 0 || it.bytes < min_size[rec]) min_size[rec] = it.bytes;
      if (it.bytes > max_size[rec]) max_size[rec] = it.bytes;
      r.bucket = size_bin(it.bytes);
      hist_sum[rec][r.bucket] += 1;
      if (unit_bytes != 0) begin
         span = '0;
         if (it.bytes != 0) begin
            first_byte = {10'b0, it.sector} << SECTOR_SHIFT;
            last_byte = first_byte + it.bytes - 1;
            span = (last_byte / unit_bytes - first_byte / unit_bytes + 1) * unit_bytes;
         end
         span_sum[rec] += span;
         r.span = span;
         if (it.bytes < unit_bytes) begin
            small_sum[rec] += 1;
            r.below = 1'b1;
         end
      end
      return r;
   endfunction

   // Driver.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_item <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= hold_rsp || ($urandom_range(99) < idle_pct);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      io_result_type got, exp;
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_and_update(req_item));
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_skipped, rsp_bucket, rsp_span_bytes, rsp_below_unit, rsp_counter_value};
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result item %p", got);
            end else begin
               exp = expected_results.pop_front();
               if (got !== exp) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected %p, got %p", exp, got);
               end
            end
         end
      end
   end

   function automatic io_item_type random_item();
      io_item_type it;
      it.mode = ($urandom_range(99) < 30) ? MODE_READ : MODE_RECORD;
      it.op = ($urandom_range(99) < 8) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
      it.dev = $urandom_range(99) < 60 ? 4'($urandom_range(3)) : 4'($urandom);
      case ($urandom_range(5))
         0: it.bytes = $urandom;
         1: it.bytes = 32'($urandom_range(0, 4096));
         2: it.bytes = 32'(512) << $urandom_range(0, 14);
         default: it.bytes = 32'($urandom_range(0, 1 << 21));
      endcase
      it.sector = ($urandom_range(3) == 0) ? 54'({$urandom, $urandom}) :
                                             54'($urandom_range(0, 1 << 16));
      it.sel = ($urandom_range(19) == 0) ? 5'($urandom) : 5'($urandom_range(SEL_MAX));
      return it;
   endfunction

   task automatic wait_drain();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_unit(logic [UNIT_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      unit_bytes = value;
   endtask

   task automatic add_item(logic m, logic [1:0] o, logic [3:0] d, logic [31:0] b,
                           logic [53:0] s, logic [4:0] c);
      pending_items.push_back('{m, o, d, b, s, c});
   endtask

   initial begin
      for (int r = 0; r < RECS; r++) begin
         byte_sum[r] = 0; req_sum[r] = 0; span_sum[r] = 0; small_sum[r] = 0;
         min_size[r] = 0; max_size[r] = 0;
         for (int b = 0; b < NBKT; b++) hist_sum[r][b] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_unit(21'd4096);
      // Directed: extremes, other ops, zero bytes, bad selector, reads of every counter.
      add_item(MODE_RECORD, OP_READ, 4'd0, 32'd0, 54'd0, 5'd0);
      add_item(MODE_RECORD, OP_READ, 4'd0, 32'hFFFFFFFF, '1, 5'd31);
      add_item(MODE_RECORD, OP_WRITE, 4'd15, 32'd512, 54'd7, 5'd0);
      add_item(MODE_RECORD, OP_WRITE, 4'd15, 32'd1048576, 54'd3, 5'd0);
      add_item(MODE_RECORD, OP_OTHER, 4'd3, 32'd100, 54'd1, 5'd0);
      add_item(MODE_RECORD, OP_OTHER3, 4'd3, 32'd100, 54'd1, 5'd0);
      add_item(MODE_RECORD, OP_READ, 4'd0, 32'd1023, 54'd8, 5'd0);
      for (int s = 0; s <= SEL_MAX; s++) add_item(MODE_READ, OP_READ, 4'd0, '1, '1, 5'(s));
      add_item(MODE_READ, OP_WRITE, 4'd15, 32'd0, 54'd0, SEL_MIN);
      add_item(MODE_READ, OP_OTHER, 4'd0, 32'd0, 54'd0, SEL_BYTES);
      add_item(MODE_READ, OP_WRITE, 4'd15, 32'd0, 54'd0, 5'd31);
      wait_drain();
      // Random phases with different unit sizes, extremes included.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_unit(21'd0);
            1: write_unit(21'd1);
            2: write_unit(21'd1048576);
            3: write_unit(21'h1FFFFF);
            default: write_unit(21'($urandom_range(1, 65536)));
         endcase
         idle_pct = (ph == 2) ? 0 : 15;
         for (int i = 0; i < 90; i++) pending_items.push_back(random_item());
         if (ph == 1) begin
            // Hold off the receiver while the sender keeps offering items.
            hold_rsp = 1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         wait_drain();
      end
      if (mismatches == 0 && expected_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
